@@ rtl/core/fasta_residue_counter_unit_macros.svh @@
// Assertion helpers shared by the checker files of this block.
// Every macro samples on clk_i and is switched off while rst_ni is low.
`ifndef FASTA_RESIDUE_COUNTER_UNIT_MACROS_SVH
`define FASTA_RESIDUE_COUNTER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FRU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FRU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/fru_pkg.sv @@
`timescale 1ns / 1ps

package fru_pkg;

  localparam int unsigned COUNT_BITS_DEF = 32;
  localparam int unsigned NUM_BINS_DEF   = 29;

  // Character codes the parser reacts to.
  localparam logic [7:0] CHAR_NUL  = 8'h00;
  localparam logic [7:0] CHAR_NL   = 8'h0A;
  localparam logic [7:0] CHAR_GT   = 8'h3E;
  localparam logic [7:0] CHAR_STAR = 8'h2A;
  localparam logic [7:0] CHAR_DASH = 8'h2D;
  localparam logic [7:0] CHAR_UA   = 8'h41;
  localparam logic [7:0] CHAR_UZ   = 8'h5A;
  localparam logic [7:0] CHAR_LA   = 8'h61;
  localparam logic [7:0] CHAR_LZ   = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // Fixed bin positions of the non-letter residues.
  localparam logic [7:0] NUM_LETTERS = 8'd26;
  localparam logic [7:0] BIN_STAR    = 8'd26;
  localparam logic [7:0] BIN_DASH    = 8'd27;

  // Result kinds.
  localparam logic [1:0] KIND_REC_BIN = 2'd0;
  localparam logic [1:0] KIND_REC_LEN = 2'd1;
  localparam logic [1:0] KIND_TOT_BIN = 2'd2;
  localparam logic [1:0] KIND_TOT_LEN = 2'd3;

  localparam logic [15:0] RECORDS_MAX = 16'hFFFF;
  localparam logic [63:0] COUNT_OUT_MAX = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_marker;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  residue_code;
    logic [31:0] count_value;
    logic [15:0] record_number;
    logic        last_of_run;
  } out_item_t;

  // Commands from the sequencer to one bin memory.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_all;
  } mem_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INC_REC,
    ST_INC_TOT,
    ST_INC_RLEN,
    ST_INC_TLEN,
    ST_EMIT_RD,
    ST_EMIT_CHK,
    ST_EMIT_LEN
  } state_e;

  // Bin of a byte: letters fold to upper case, anything unknown goes to the
  // other bin, and so does a fixed bin that lies at or beyond it.
  function automatic logic [7:0] bin_of(input logic [7:0] b, input logic [7:0] other);
    logic [7:0] u;
    logic [7:0] idx;
    u = b;
    if (b >= CHAR_LA && b <= CHAR_LZ) u = b - CASE_OFFSET;
    if (u >= CHAR_UA && u <= CHAR_UZ) idx = u - CHAR_UA;
    else if (u == CHAR_STAR) idx = BIN_STAR;
    else if (u == CHAR_DASH) idx = BIN_DASH;
    else idx = other;
    if (idx > other) idx = other;
    return idx;
  endfunction

  // Residue code reported for a bin; the other bin reports zero.
  function automatic logic [7:0] code_of(input logic [7:0] idx, input logic [7:0] other);
    logic [7:0] c;
    if (idx == other) c = CHAR_NUL;
    else if (idx < NUM_LETTERS) c = CHAR_UA + idx;
    else if (idx == BIN_STAR) c = CHAR_STAR;
    else if (idx == BIN_DASH) c = CHAR_DASH;
    else c = CHAR_NUL;
    return c;
  endfunction

  // Counts wider than the result field are reported as all ones.
  function automatic logic [31:0] clamp32(input logic [63:0] v);
    logic [31:0] r;
    if (v > COUNT_OUT_MAX) r = '1;
    else r = v[31:0];
    return r;
  endfunction

endpackage

@@ rtl/core/fru_sat_inc.sv @@
`timescale 1ns / 1ps

module fru_sat_inc #(
  parameter int unsigned WIDTH = 32
) (
  input  logic [WIDTH-1:0] operand_i,
  output logic [WIDTH-1:0] result_o
);

  // The count sticks at all ones instead of wrapping.
  assign result_o = (&operand_i) ? operand_i : operand_i + WIDTH'(1);

endmodule

@@ rtl/core/fru_bin_mem.sv @@
`timescale 1ns / 1ps

module fru_bin_mem
  import fru_pkg::*;
#(
  parameter int unsigned DEPTH  = NUM_BINS_DEF,
  parameter int unsigned WIDTH  = COUNT_BITS_DEF,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mem_cmd_t          cmd_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  output logic [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [DEPTH-1:0] valid_d;
  logic [WIDTH-1:0] rd_data_q;

  // An entry whose valid bit is clear reads as zero.
  always_comb begin
    valid_d = valid_q;
    if (cmd_i.wr_en) valid_d[wr_addr_i] = 1'b1;
    if (cmd_i.clr_all) valid_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_data_q <= valid_q[rd_addr_i] ? mem[rd_addr_i] : '0;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/core/fasta_residue_counter_unit.sv @@
`timescale 1ns / 1ps
// Residue composition counter for a FASTA byte stream.
// Input channel: one transaction carries one file byte, or the end marker.
// The unit raises in_stall_o while it works on a transaction.
// A newline, a zero byte, a header byte or a header that opens the first
// record is handled on acceptance. A sequence byte first reads its two
// bins, then takes four steps of the shared saturating incrementer
// (record bin, total bin, record length, total length).
// A header after an open record, and the end marker, start a flush run:
// each bin is a memory read, then a check and send step; a nonzero
// bin is sent as one result transaction, and the run closes with a length
// result that has last_of_run set. The end marker sends the record run and
// then the totals run and returns every counter to zero.
// Output channel: a result register holds each result until the receiver
// drops out_stall_i; a stalled receiver only pauses the flush sequencer.
// Reset clears all counters and the line state at once; the bin memories
// use per-entry valid bits, so no clearing pass follows reset.

module fasta_residue_counter_unit
  import fru_pkg::*;
#(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF,
  parameter int unsigned NUM_BINS   = NUM_BINS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned IDX_W = $clog2(NUM_BINS);
  localparam logic [7:0] OTHER_BIN = 8'(NUM_BINS - 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BINS - 1);

  state_e state_q, state_d;

  logic                  at_line_start_q, at_line_start_d;
  logic                  in_header_q, in_header_d;
  logic [15:0]           records_q, records_d;
  logic [COUNT_BITS-1:0] rec_len_q, rec_len_d;
  logic [COUNT_BITS-1:0] tot_len_q, tot_len_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [IDX_W-1:0]      emit_idx_q, emit_idx_d;
  logic                  run_sel_q, run_sel_d;
  logic                  final_q, final_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_q, out_d;

  mem_cmd_t              rec_cmd, tot_cmd;
  logic [IDX_W-1:0]      rd_addr;
  logic [COUNT_BITS-1:0] rec_rd, tot_rd;
  logic [COUNT_BITS-1:0] sat_operand, sat_result;

  logic                  accept;
  logic                  out_free;
  logic [7:0]            byte_bin_wide;
  logic [IDX_W-1:0]      byte_bin;
  logic                  is_end, is_nul, is_nl, is_gt;
  logic                  opens_header, counts_byte;
  logic [COUNT_BITS-1:0] emit_bin;
  logic                  bin_nonzero;
  logic [COUNT_BITS-1:0] emit_len;
  logic                  do_open, do_clear;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // Byte classification. A header byte is ignored until its newline.
  assign is_end = in_data_i.end_marker;
  assign is_nul = (in_data_i.data_byte == CHAR_NUL);
  assign is_nl  = (in_data_i.data_byte == CHAR_NL);
  assign is_gt  = (in_data_i.data_byte == CHAR_GT);
  assign opens_header = !is_end && !is_nul && !in_header_q && at_line_start_q && is_gt;
  assign counts_byte  = !is_end && !is_nul && !in_header_q && !opens_header && !is_nl;

  assign byte_bin_wide = bin_of(in_data_i.data_byte, OTHER_BIN);
  assign byte_bin      = byte_bin_wide[IDX_W-1:0];

  assign emit_bin    = run_sel_q ? tot_rd : rec_rd;
  assign bin_nonzero = (emit_bin != '0);
  assign emit_len    = run_sel_q ? tot_len_q : rec_len_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (is_end) state_d = ST_EMIT_RD;
          else if (opens_header && (records_q != '0)) state_d = ST_EMIT_RD;
          else if (counts_byte) state_d = ST_INC_REC;
        end
      end
      ST_INC_REC:  state_d = ST_INC_TOT;
      ST_INC_TOT:  state_d = ST_INC_RLEN;
      ST_INC_RLEN: state_d = ST_INC_TLEN;
      ST_INC_TLEN: state_d = ST_IDLE;
      ST_EMIT_RD:  state_d = ST_EMIT_CHK;
      ST_EMIT_CHK: begin
        if (!bin_nonzero || out_free) begin
          state_d = (emit_idx_q == LAST_IDX) ? ST_EMIT_LEN : ST_EMIT_RD;
        end
      end
      ST_EMIT_LEN: begin
        if (out_free) begin
          state_d = (!run_sel_q && final_q) ? ST_EMIT_RD : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath control and outputs.
  always_comb begin
    at_line_start_d = at_line_start_q;
    in_header_d     = in_header_q;
    records_d       = records_q;
    rec_len_d       = rec_len_q;
    tot_len_d       = tot_len_q;
    idx_d           = idx_q;
    emit_idx_d      = emit_idx_q;
    run_sel_d       = run_sel_q;
    final_d         = final_q;
    out_d           = out_q;
    out_valid_d     = out_valid_q && out_stall_i;
    do_open         = 1'b0;
    do_clear        = 1'b0;
    rec_cmd         = '0;
    tot_cmd         = '0;
    rd_addr         = byte_bin;
    sat_operand     = tot_len_q;

    case (state_q)
      ST_IDLE: begin
        rec_cmd.rd_en = accept;
        tot_cmd.rd_en = accept;
        if (accept) begin
          if (is_end) begin
            run_sel_d  = 1'b0;
            final_d    = 1'b1;
            emit_idx_d = '0;
          end else if (!is_nul && in_header_q) begin
            if (is_nl) begin
              in_header_d     = 1'b0;
              at_line_start_d = 1'b1;
            end
          end else if (opens_header) begin
            if (records_q != '0) begin
              run_sel_d  = 1'b0;
              final_d    = 1'b0;
              emit_idx_d = '0;
            end else begin
              do_open = 1'b1;
            end
          end else if (!is_nul && is_nl) begin
            at_line_start_d = 1'b1;
          end else if (counts_byte) begin
            at_line_start_d = 1'b0;
            idx_d           = byte_bin;
          end
        end
      end
      ST_INC_REC: begin
        sat_operand   = rec_rd;
        rec_cmd.wr_en = 1'b1;
      end
      ST_INC_TOT: begin
        sat_operand   = tot_rd;
        tot_cmd.wr_en = 1'b1;
      end
      ST_INC_RLEN: begin
        sat_operand = rec_len_q;
        rec_len_d   = sat_result;
      end
      ST_INC_TLEN: begin
        sat_operand = tot_len_q;
        tot_len_d   = sat_result;
      end
      ST_EMIT_RD: begin
        rd_addr       = emit_idx_q;
        rec_cmd.rd_en = 1'b1;
        tot_cmd.rd_en = 1'b1;
      end
      ST_EMIT_CHK: begin
        if (!bin_nonzero || out_free) begin
          if (bin_nonzero) begin
            out_valid_d         = 1'b1;
            out_d.kind          = run_sel_q ? KIND_TOT_BIN : KIND_REC_BIN;
            out_d.residue_code  = code_of(8'(emit_idx_q), OTHER_BIN);
            out_d.count_value   = clamp32(64'(emit_bin));
            out_d.record_number = records_q;
            out_d.last_of_run   = 1'b0;
          end
          if (emit_idx_q != LAST_IDX) emit_idx_d = emit_idx_q + IDX_W'(1);
        end
      end
      ST_EMIT_LEN: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.kind          = run_sel_q ? KIND_TOT_LEN : KIND_REC_LEN;
          out_d.residue_code  = CHAR_NUL;
          out_d.count_value   = clamp32(64'(emit_len));
          out_d.record_number = records_q;
          out_d.last_of_run   = 1'b1;
          if (run_sel_q) begin
            do_clear = 1'b1;
          end else if (final_q) begin
            run_sel_d  = 1'b1;
            emit_idx_d = '0;
          end else begin
            do_open = 1'b1;
          end
        end
      end
      default: begin
        sat_operand = tot_len_q;
      end
    endcase

    // A header line opens a fresh record.
    if (do_open) begin
      records_d       = (records_q == RECORDS_MAX) ? records_q : records_q + 16'd1;
      rec_len_d       = '0;
      in_header_d     = 1'b1;
      at_line_start_d = 1'b0;
    end

    // End of input returns every counter to its reset value.
    if (do_clear) begin
      records_d       = '0;
      rec_len_d       = '0;
      tot_len_d       = '0;
      in_header_d     = 1'b0;
      at_line_start_d = 1'b1;
      run_sel_d       = 1'b0;
      final_d         = 1'b0;
    end

    rec_cmd.clr_all = do_open || do_clear;
    tot_cmd.clr_all = do_clear;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      at_line_start_q <= 1'b1;
      in_header_q     <= 1'b0;
      records_q       <= '0;
      rec_len_q       <= '0;
      tot_len_q       <= '0;
      emit_idx_q      <= '0;
      run_sel_q       <= 1'b0;
      final_q         <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q         <= state_d;
      at_line_start_q <= at_line_start_d;
      in_header_q     <= in_header_d;
      records_q       <= records_d;
      rec_len_q       <= rec_len_d;
      tot_len_q       <= tot_len_d;
      emit_idx_q      <= emit_idx_d;
      run_sel_q       <= run_sel_d;
      final_q         <= final_d;
      out_valid_q     <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    out_q <= out_d;
  end

  fru_sat_inc #(
    .WIDTH(COUNT_BITS)
  ) u_sat_inc (
    .operand_i(sat_operand),
    .result_o (sat_result)
  );

  fru_bin_mem #(
    .DEPTH (NUM_BINS),
    .WIDTH (COUNT_BITS),
    .ADDR_W(IDX_W)
  ) u_rec_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (rec_cmd),
    .rd_addr_i(rd_addr),
    .wr_addr_i(idx_q),
    .wr_data_i(sat_result),
    .rd_data_o(rec_rd)
  );

  fru_bin_mem #(
    .DEPTH (NUM_BINS),
    .WIDTH (COUNT_BITS),
    .ADDR_W(IDX_W)
  ) u_tot_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (tot_cmd),
    .rd_addr_i(rd_addr),
    .wr_addr_i(idx_q),
    .wr_data_i(sat_result),
    .rd_data_o(tot_rd)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/core/fru_checker.sv @@
`timescale 1ns / 1ps
`include "fasta_residue_counter_unit_macros.svh"

module fru_checker
  import fru_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  // A stalled result stays offered.
  `FRU_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")

  // The end marker always starts a flush, so the input side is busy next cycle.
  `FRU_ASSERT_NEXT(a_end_busy, in_valid_i && !in_stall_o && in_data_i.end_marker, in_stall_o, "end marker did not start a flush")

  // Only length results close a run, and they carry no residue code.
  `FRU_ASSERT_NOW(a_last_is_len, out_valid_o && out_data_o.last_of_run, out_data_o.kind[0] && (out_data_o.residue_code == CHAR_NUL), "run closed by a bin result")

  // Every length result closes its run.
  `FRU_ASSERT_NOW(a_len_is_last, out_valid_o && out_data_o.kind[0], out_data_o.last_of_run, "length result without run end")

endmodule

bind fasta_residue_counter_unit fru_checker u_fru_checker (.*);
